// ----- design/exchange_effective_field_unit_assert.svh -----
// Assertion macros used by the exchange field unit.
`ifndef EXCHANGE_EFFECTIVE_FIELD_UNIT_ASSERT_SVH
`define EXCHANGE_EFFECTIVE_FIELD_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EEF_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EEF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/eef_pkg.sv -----
package eef_pkg;

    localparam int VAL_W = 32;
    localparam int NB_W  = 10;
    localparam int MOM_W = 3 * VAL_W;
    localparam int ENT_W = NB_W + VAL_W;

    typedef enum logic [1:0] {
        CMD_MOMENT  = 2'd0,
        CMD_ENTRY   = 2'd1,
        CMD_COUNT   = 2'd2,
        CMD_COMPUTE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_WALK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic prod_en;
        logic acc_en;
    } t_mac_ctl;

endpackage

// ----- design/eef_store.sv -----
module eef_store
    import eef_pkg::*;
#(
    parameter int CNT_AW = 10,
    parameter int CNT_W  = 6,
    parameter int TAB_AW = 15,
    parameter int MOM_AW = 12
) (
    input  logic              i_clk,
    input  logic              i_cnt_we,
    input  logic [CNT_AW-1:0] i_cnt_waddr,
    input  logic [CNT_W-1:0]  i_cnt_wdata,
    input  logic [CNT_AW-1:0] i_cnt_raddr,
    output logic [CNT_W-1:0]  o_cnt_rdata,
    input  logic              i_tab_we,
    input  logic [TAB_AW-1:0] i_tab_waddr,
    input  logic [ENT_W-1:0]  i_tab_wdata,
    input  logic [TAB_AW-1:0] i_tab_raddr,
    output logic [ENT_W-1:0]  o_tab_rdata,
    input  logic              i_mom_we,
    input  logic [MOM_AW-1:0] i_mom_waddr,
    input  logic [MOM_W-1:0]  i_mom_wdata,
    input  logic [MOM_AW-1:0] i_mom_raddr,
    output logic [MOM_W-1:0]  o_mom_rdata
);

    logic [CNT_W-1:0] r_cnt_mem [2**CNT_AW];
    logic [ENT_W-1:0] r_tab_mem [2**TAB_AW];
    logic [MOM_W-1:0] r_mom_mem [2**MOM_AW];

    always_ff @(posedge i_clk) begin
        if (i_cnt_we) begin
            r_cnt_mem[i_cnt_waddr] <= i_cnt_wdata;
        end
        o_cnt_rdata <= r_cnt_mem[i_cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_tab_we) begin
            r_tab_mem[i_tab_waddr] <= i_tab_wdata;
        end
        o_tab_rdata <= r_tab_mem[i_tab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_mom_we) begin
            r_mom_mem[i_mom_waddr] <= i_mom_wdata;
        end
        o_mom_rdata <= r_mom_mem[i_mom_raddr];
    end

endmodule

// ----- design/eef_mac.sv -----
module eef_mac
    import eef_pkg::*;
#(
    parameter int ACC_W = 55
) (
    input  logic             i_clk,
    input  t_mac_ctl         i_ctl,
    input  logic [MOM_W-1:0] i_field,
    input  logic [VAL_W-1:0] i_coup,
    input  logic [MOM_W-1:0] i_moment,
    output logic [MOM_W-1:0] o_result,
    output logic             o_sat
);

    logic signed [2*VAL_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]   r_acc  [3];
    logic [2:0]                clip;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [VAL_W-1:0] coup_s;
        logic signed [VAL_W-1:0] mom_s;
        logic signed [VAL_W-1:0] fld_s;
        logic signed [2*VAL_W-17:0] prod_q;
        logic [ACC_W-VAL_W:0] top_bits;

        assign coup_s   = signed'(i_coup);
        assign mom_s    = signed'(i_moment[g*VAL_W +: VAL_W]);
        assign fld_s    = signed'(i_field[g*VAL_W +: VAL_W]);
        // Dropping the low 16 bits of a two's complement product floors it.
        assign prod_q   = signed'(r_prod[g][2*VAL_W-1:16]);
        assign top_bits = r_acc[g][ACC_W-1:VAL_W-1];

        always_ff @(posedge i_clk) begin
            if (i_ctl.prod_en) begin
                r_prod[g] <= coup_s * mom_s;
            end
            if (i_ctl.load) begin
                r_acc[g] <= ACC_W'(fld_s);
            end else if (i_ctl.acc_en) begin
                r_acc[g] <= r_acc[g] + ACC_W'(prod_q);
            end
        end

        always_comb begin
            clip[g] = !((&top_bits) || !(|top_bits));
            if (!clip[g]) begin
                o_result[g*VAL_W +: VAL_W] = r_acc[g][VAL_W-1:0];
            end else if (r_acc[g][ACC_W-1]) begin
                o_result[g*VAL_W +: VAL_W] = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                o_result[g*VAL_W +: VAL_W] = {1'b0, {(VAL_W-1){1'b1}}};
            end
        end
    end

    assign o_sat = |clip;

endmodule

// ----- design/exchange_effective_field_unit.sv -----
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   command, atom, ensemble, slot, neighbour
//                                                fields, count, value_x/y/z
// result    out        o_out_valid / i_out_stall field_x/y/z, saturated
//
// Write requests leave the block idle, ready for the next request. A compute request reads
// the atom's neighbour count and walks its list; no request is taken until it is back in
// idle. The neighbour walk reads one table entry and one moment per cycle through a
// three-deep read and multiply pipe.
// After reset a clearing pass zeroes the neighbour counts; no request is taken until it
// ends. A stalled result holds in the output register while the next request is taken;
// a compute waits at its end until that register is free.
module exchange_effective_field_unit
    import eef_pkg::*;
#(
    parameter int ATOMS          = 1024,
    parameter int ENSEMBLES      = 4,
    parameter int MAX_NEIGHBOURS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_atom,
    input  logic [1:0]  i_ensemble,
    input  logic [4:0]  i_slot,
    input  logic [9:0]  i_neighbour_atom,
    input  logic signed [31:0] i_coupling,
    input  logic [5:0]  i_neighbour_count,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [31:0] i_value_z,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_field_x,
    output logic signed [31:0] o_field_y,
    output logic signed [31:0] o_field_z,
    output logic        o_saturated
);

    localparam int CNT_AW = $clog2(ATOMS);
    localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
    localparam int TAB_AW = $clog2(ATOMS * MAX_NEIGHBOURS);
    localparam int MOM_AW = (ATOMS * ENSEMBLES > 2) ? $clog2(ATOMS * ENSEMBLES) : 1;
    localparam int ACC_W  = 2 * VAL_W - 16 + CNT_W + 1;

    t_state           r_state, n_state;
    t_mac_ctl         mac_ctl;
    logic [CNT_AW-1:0] r_clr;
    logic [31:0]      r_atom, r_ens;
    logic             r_ok;
    logic [MOM_W-1:0] r_field;
    logic [CNT_W-1:0] r_n, r_j;
    logic             r_p1, r_p2, r_p3;
    logic [VAL_W-1:0] r_coup2;
    logic             r_out_valid;
    logic [MOM_W-1:0] r_out;
    logic             r_out_sat;

    logic [31:0]      atom_w, ens_w, slot_w, cnt_w, nb_w;
    logic             in_acc, atom_ok, ens_ok, issue, walk_done, out_free;
    t_cmd             cmd;
    logic             cnt_we, tab_we, mom_we;
    logic [CNT_AW-1:0] cnt_waddr;
    logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
    logic [ENT_W-1:0] tab_rdata;
    logic [MOM_W-1:0] mom_rdata, mac_result;
    logic             mac_sat;
    logic [31:0]      tab_waddr_w, tab_raddr_w, mom_waddr_w, mom_raddr_w;

    assign atom_w  = 32'(i_atom);
    assign ens_w   = 32'(i_ensemble);
    assign slot_w  = 32'(i_slot);
    assign cnt_w   = 32'(i_neighbour_count);
    assign nb_w    = 32'(tab_rdata[ENT_W-1:VAL_W]);
    assign cmd     = t_cmd'(i_command);
    assign in_acc  = i_in_valid && !o_in_stall;
    assign atom_ok = atom_w < 32'(ATOMS);
    assign ens_ok  = ens_w < 32'(ENSEMBLES);

    assign issue     = r_j < r_n;
    assign walk_done = !issue && !r_p1 && !r_p2 && !r_p3;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Store addressing.
    assign tab_waddr_w = atom_w * 32'(MAX_NEIGHBOURS) + slot_w;
    assign mom_waddr_w = atom_w * 32'(ENSEMBLES) + ens_w;
    assign tab_raddr_w = r_atom * 32'(MAX_NEIGHBOURS) + 32'(r_j);
    assign mom_raddr_w = nb_w * 32'(ENSEMBLES) + r_ens;

    assign mom_we = in_acc && cmd == CMD_MOMENT && atom_ok && ens_ok;
    assign tab_we = in_acc && cmd == CMD_ENTRY && atom_ok && slot_w < 32'(MAX_NEIGHBOURS);

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = atom_w[CNT_AW-1:0];
        cnt_wdata = '0;
        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr;
        end else if (in_acc && cmd == CMD_COUNT && atom_ok) begin
            cnt_we = 1'b1;
            if (cnt_w > 32'(MAX_NEIGHBOURS)) begin
                cnt_wdata = CNT_W'(MAX_NEIGHBOURS);
            end else begin
                cnt_wdata = CNT_W'(cnt_w);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CNT_AW'(ATOMS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc && cmd == CMD_COMPUTE) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall      = 1'b1;
        mac_ctl.load    = 1'b0;
        mac_ctl.prod_en = r_p2;
        mac_ctl.acc_en  = r_p3;
        unique case (r_state)
            S_IDLE:  o_in_stall   = 1'b0;
            S_COUNT: mac_ctl.load = 1'b1;
            S_CLEAR, S_WALK, S_FINISH: o_in_stall = 1'b1;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_p3        <= 1'b0;
            r_j         <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_COUNT) begin
                r_n <= r_ok ? cnt_rdata : '0;
                r_j <= '0;
            end else if (r_state == S_WALK && issue) begin
                r_j <= r_j + 1'b1;
            end
            r_p1 <= r_state == S_WALK && issue;
            r_p2 <= r_p1 && nb_w < 32'(ATOMS);
            r_p3 <= r_p2;
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_atom  <= atom_w;
            r_ens   <= ens_w;
            r_ok    <= atom_ok && ens_ok;
            r_field <= {i_value_z, i_value_y, i_value_x};
        end
        r_coup2 <= tab_rdata[VAL_W-1:0];
        if (r_state == S_FINISH && out_free) begin
            r_out     <= mac_result;
            r_out_sat <= mac_sat;
        end
    end

    eef_store #(
        .CNT_AW (CNT_AW),
        .CNT_W  (CNT_W),
        .TAB_AW (TAB_AW),
        .MOM_AW (MOM_AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_cnt_we    (cnt_we),
        .i_cnt_waddr (cnt_waddr),
        .i_cnt_wdata (cnt_wdata),
        .i_cnt_raddr (atom_w[CNT_AW-1:0]),
        .o_cnt_rdata (cnt_rdata),
        .i_tab_we    (tab_we),
        .i_tab_waddr (tab_waddr_w[TAB_AW-1:0]),
        .i_tab_wdata ({i_neighbour_atom, i_coupling}),
        .i_tab_raddr (tab_raddr_w[TAB_AW-1:0]),
        .o_tab_rdata (tab_rdata),
        .i_mom_we    (mom_we),
        .i_mom_waddr (mom_waddr_w[MOM_AW-1:0]),
        .i_mom_wdata ({i_value_z, i_value_y, i_value_x}),
        .i_mom_raddr (mom_raddr_w[MOM_AW-1:0]),
        .o_mom_rdata (mom_rdata)
    );

    eef_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_field  (r_field),
        .i_coup   (r_coup2),
        .i_moment (mom_rdata),
        .o_result (mac_result),
        .o_sat    (mac_sat)
    );

    assign o_out_valid = r_out_valid;
    assign o_field_x   = signed'(r_out[VAL_W-1:0]);
    assign o_field_y   = signed'(r_out[2*VAL_W-1:VAL_W]);
    assign o_field_z   = signed'(r_out[3*VAL_W-1:2*VAL_W]);
    assign o_saturated = r_out_sat;

`include "exchange_effective_field_unit_assert.svh"

    `EEF_CHECK_NOW(a_walk_bound, r_state == S_WALK, r_j <= r_n, "walk index passed count")
    `EEF_CHECK_NOW(a_pipe_empty, r_state == S_FINISH, !r_p1 && !r_p2 && !r_p3,
                   "pipe not drained at finish")
    `EEF_CHECK_NOW(a_result_src, $rose(r_out_valid), $past(r_state) == S_FINISH,
                   "result raised outside finish")
    `EEF_CHECK_NOW(a_clear_hold, r_state == S_CLEAR, o_in_stall,
                   "request taken during clearing pass")

endmodule

// ----- bench/tb_exchange_effective_field_unit.sv -----
`timescale 1ns / 100ps

module tb_exchange_effective_field_unit;
    import eef_pkg::*;

    localparam int N_ATOMS   = 1024;
    localparam int N_ENS     = 4;
    localparam int N_SLOTS   = 32;
    localparam int CYCLE_CAP = 2000000;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               sat;
    } t_field;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_command;
    logic [9:0]        i_atom;
    logic [1:0]        i_ensemble;
    logic [4:0]        i_slot;
    logic [9:0]        i_neighbour_atom;
    logic signed [31:0] i_coupling;
    logic [5:0]        i_neighbour_count;
    logic signed [31:0] i_value_x;
    logic signed [31:0] i_value_y;
    logic signed [31:0] i_value_z;
    logic              o_out_valid;
    logic              i_out_stall;
    logic signed [31:0] o_field_x;
    logic signed [31:0] o_field_y;
    logic signed [31:0] o_field_z;
    logic              o_saturated;

    // Shadow copy of the block's stores, with flags for entries written so far.
    logic signed [31:0] moment_x [N_ATOMS*N_ENS];
    logic signed [31:0] moment_y [N_ATOMS*N_ENS];
    logic signed [31:0] moment_z [N_ATOMS*N_ENS];
    bit                 moment_ok [N_ATOMS*N_ENS];
    logic [9:0]         entry_nb [N_ATOMS*N_SLOTS];
    logic signed [31:0] entry_coup [N_ATOMS*N_SLOTS];
    bit                 entry_ok [N_ATOMS*N_SLOTS];
    int unsigned        list_len [N_ATOMS];

    t_field      field_q[$];
    int unsigned fail_count;
    int unsigned request_count;
    int unsigned cycle_count;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned hold_left;

    exchange_effective_field_unit i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("exchange_effective_field_unit regression: fail");
            $finish;
        end
    end

    // Receiver: a long hold-off when asked for, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_field want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (field_q.size() == 0) begin
                $display("%0t: result with none expected: %h %h %h %b", $time,
                         o_field_x, o_field_y, o_field_z, o_saturated);
                fail_count++;
            end else begin
                want = field_q.pop_front();
                if (o_field_x !== want.fx || o_field_y !== want.fy ||
                    o_field_z !== want.fz || o_saturated !== want.sat) begin
                    $display("%0t: field mismatch: expected %h %h %h %b, got %h %h %h %b",
                             $time, want.fx, want.fy, want.fz, want.sat,
                             o_field_x, o_field_y, o_field_z, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] clip_sum(input longint s, inout logic sat);
        if (s > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (s < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    function automatic t_field exchange_field(input int unsigned atom, input int unsigned ens,
                                              input logic signed [31:0] hx, hy, hz);
        t_field f;
        longint ax, ay, az, c;
        int unsigned m;
        ax = hx;
        ay = hy;
        az = hz;
        for (int j = 0; j < list_len[atom]; j++) begin
            c = entry_coup[atom*N_SLOTS+j];
            m = entry_nb[atom*N_SLOTS+j] * N_ENS + ens;
            // The arithmetic shift floors the Q32.32 product to Q16.16.
            ax += (c * longint'(moment_x[m])) >>> 16;
            ay += (c * longint'(moment_y[m])) >>> 16;
            az += (c * longint'(moment_z[m])) >>> 16;
        end
        f.sat = 1'b0;
        f.fx = clip_sum(ax, f.sat);
        f.fy = clip_sum(ay, f.sat);
        f.fz = clip_sum(az, f.sat);
        return f;
    endfunction

    function automatic logic signed [31:0] rand_q();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0) return 32'sh7fffffff;
        if (r == 1) return 32'sh80000000;
        if (r < 5) return $urandom;
        return $signed($urandom_range(524287)) - 32'sd262144;
    endfunction

    task automatic send_request(input t_cmd cmd, input logic [9:0] atom,
                                input logic [1:0] ens, input logic [4:0] slot,
                                input logic [9:0] nb, input logic signed [31:0] coup,
                                input logic [5:0] count,
                                input logic signed [31:0] vx, vy, vz);
        int unsigned k;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_command         = cmd;
        i_atom            = atom;
        i_ensemble        = ens;
        i_slot            = slot;
        i_neighbour_atom  = nb;
        i_coupling        = coup;
        i_neighbour_count = count;
        i_value_x         = vx;
        i_value_y         = vy;
        i_value_z         = vz;
        i_in_valid        = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        request_count++;
        case (cmd)
            CMD_MOMENT: begin
                k = atom * N_ENS + ens;
                moment_x[k] = vx;
                moment_y[k] = vy;
                moment_z[k] = vz;
                moment_ok[k] = 1'b1;
            end
            CMD_ENTRY: begin
                k = atom * N_SLOTS + slot;
                entry_nb[k] = nb;
                entry_coup[k] = coup;
                entry_ok[k] = 1'b1;
            end
            CMD_COUNT: list_len[atom] = (count > N_SLOTS) ? N_SLOTS : count;
            CMD_COMPUTE: field_q.push_back(exchange_field(atom, ens, vx, vy, vz));
        endcase
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_moment(input int unsigned atom, ens,
                                input logic signed [31:0] x, y, z);
        send_request(CMD_MOMENT, 10'(atom), 2'(ens), 5'($urandom), 10'($urandom),
                     $urandom, 6'($urandom), x, y, z);
    endtask

    task automatic write_entry(input int unsigned atom, slot, nb,
                               input logic signed [31:0] coup);
        send_request(CMD_ENTRY, 10'(atom), 2'($urandom), 5'(slot), 10'(nb), coup,
                     6'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic write_count(input int unsigned atom, count);
        send_request(CMD_COUNT, 10'(atom), 2'($urandom), 5'($urandom), 10'($urandom),
                     $urandom, 6'(count), $urandom, $urandom, $urandom);
    endtask

    // Fills every table entry and moment the compute will read before issuing it,
    // so that no read the compute uses touches an unwritten location.
    task automatic compute_field(input int unsigned atom, ens,
                                 input logic signed [31:0] hx, hy, hz);
        int unsigned nb;
        for (int j = 0; j < list_len[atom]; j++)
            if (!entry_ok[atom*N_SLOTS+j])
                write_entry(atom, j, $urandom_range(N_ATOMS-1), rand_q());
        for (int j = 0; j < list_len[atom]; j++) begin
            nb = entry_nb[atom*N_SLOTS+j];
            if (!moment_ok[nb*N_ENS+ens])
                write_moment(nb, ens, rand_q(), rand_q(), rand_q());
        end
        send_request(CMD_COMPUTE, 10'(atom), 2'(ens), 5'($urandom), 10'($urandom),
                     $urandom, 6'($urandom), hx, hy, hz);
    endtask

    task automatic drain_results();
        while (field_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        compute_field(7, 0, 32'sh7fffffff, 32'sh80000000, 0);
        for (int e = 0; e < N_ENS; e++) begin
            write_moment(1023, e, 32'sh7fffffff, 32'sh80000000, 1);
            write_moment(0, e, 32'sh80000000, 32'sh7fffffff, -1);
        end
        write_entry(5, 0, 1023, 32'sh7fffffff);
        write_entry(5, 1, 0, 32'sh80000000);
        write_count(5, 2);
        for (int e = 0; e < N_ENS; e++)
            compute_field(5, e, 32'sh7fffffff, 32'sh80000000, 32'sh00010000);
        // A single entry of both extremes pushes the sums past either rail.
        write_count(5, 1);
        compute_field(5, 3, 32'sh7fffffff, 32'sh80000000, 0);
        // Negative products round towards minus infinity.
        write_moment(3, 0, 1, -1, 32'sh00010000);
        write_entry(9, 0, 3, -1);
        write_count(9, 1);
        compute_field(9, 0, 0, 0, 0);
        // A count above the list length is held at a full list.
        write_count(5, 63);
        compute_field(5, 2, 0, 0, 0);
        write_count(1023, 32);
        compute_field(1023, 1, 0, 0, 0);
        drain_results();
    endtask

    task automatic test_random(input int unsigned n_requests, idle, stall);
        int unsigned stop_at, atom, n, r;
        idle_pct = idle;
        stall_pct = stall;
        stop_at = request_count + n_requests;
        while (request_count < stop_at) begin
            r = $urandom_range(99);
            atom = $urandom_range(N_ATOMS-1);
            if (r < 55) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(63, 32) : $urandom_range(6);
                for (int j = 0; j < n && j < N_SLOTS; j++)
                    if ($urandom_range(3) == 0)
                        write_entry(atom, j, $urandom_range(N_ATOMS-1), rand_q());
                write_count(atom, n);
                repeat ($urandom_range(1, 2))
                    compute_field(atom, $urandom_range(N_ENS-1), rand_q(), rand_q(), rand_q());
            end else if (r < 72) begin
                write_moment(atom, $urandom_range(N_ENS-1), rand_q(), rand_q(), rand_q());
            end else if (r < 82) begin
                write_entry(atom, $urandom_range(N_SLOTS-1), $urandom_range(N_ATOMS-1),
                            rand_q());
            end else if (r < 90) begin
                write_count(atom, $urandom_range(63));
            end else begin
                compute_field(atom, $urandom_range(N_ENS-1), rand_q(), rand_q(), rand_q());
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        write_count(11, 3);
        hold_left = 600;
        repeat (40)
            compute_field(11, $urandom_range(N_ENS-1), rand_q(), rand_q(), rand_q());
        // The sender pauses here until every result is back.
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_command = CMD_MOMENT;
        i_atom = '0;
        i_ensemble = '0;
        i_slot = '0;
        i_neighbour_atom = '0;
        i_coupling = '0;
        i_neighbour_count = '0;
        i_value_x = '0;
        i_value_y = '0;
        i_value_z = '0;
        fail_count = 0;
        request_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        for (int k = 0; k < N_ATOMS; k++) list_len[k] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(440, 0, 0);
        test_random(440, 87, 0);
        test_random(440, 0, 87);
        test_backpressure();
        test_random(440, 32, 32);

        if (fail_count == 0)
            $display("exchange_effective_field_unit regression: pass");
        else
            $display("exchange_effective_field_unit regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/eef_pkg.sv
design/eef_store.sv
design/eef_mac.sv
design/exchange_effective_field_unit.sv
bench/tb_exchange_effective_field_unit.sv
